[hw/rtl/hes_pkg.sv]
// Shared types and constants for the explicit heat stencil step core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hes_pkg;

    // Fixed field widths of the streaming and configuration ports.
    localparam int VALUE_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int COLS_CFG_W = 9;
    localparam int ROW_W      = 16;
    localparam int OUT_COL_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Arithmetic widths: neighbor sum minus 4u, product with the gain, final sum.
    localparam int FRAC_W = 16;
    localparam int SUM_W  = VALUE_W + 3;
    localparam int PROD_W = SUM_W + GAIN_W + 1;
    localparam int TOT_W  = PROD_W - FRAC_W + 1;

    // Default line store depth.
    localparam int MAX_COLUMNS_DEF = 256;

    // Smallest grid dimension that is honored.
    localparam int MIN_DIM = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS      = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0]     GAIN_RST = 16'd6554;
    localparam logic [COLS_CFG_W-1:0] COLS_RST = 9'd256;
    localparam logic [ROW_W-1:0]      ROWS_RST = 16'd256;

    // Position and classification of one cell as it moves down the pipeline.
    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 interior;
        logic                 boundary;
    } t_cell_tag;

endpackage

[hw/rtl/heat_explicit_stencil_step_core.sv]
// A beat passes the input stage, sum, product and result registers before its first result shows.
// Throughput: one cell per cycle unless stalled, set by the single-port-write line
// stores; last grid row cells give two results on the one result port, in turn.
// Reset: synchronous, active low; clears positions, pipeline valids and registers.
// Line stores are not cleared; they fill as the first two rows stream through.
// Depends on hes_pkg, hes_cfg_regs, hes_line_store and hes_update_pipe.
`timescale 1ns / 1ps

module heat_explicit_stencil_step_core #(
    parameter int MAX_COLUMNS = hes_pkg::MAX_COLUMNS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                i_ready,
    input  logic signed [hes_pkg::VALUE_W-1:0]  i_cell_value,
    output logic                                o_valid,
    input  logic                                o_ready,
    output logic signed [hes_pkg::VALUE_W-1:0]  o_new_value,
    output logic [hes_pkg::ROW_W-1:0]           o_out_row,
    output logic [hes_pkg::OUT_COL_W-1:0]       o_out_column,
    output logic                                o_last_of_run,
    input  logic                                i_cfg_we,
    input  logic [hes_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hes_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNT_W = (CW + 1 > hes_pkg::COLS_CFG_W) ? CW + 1 : hes_pkg::COLS_CFG_W;

    logic [hes_pkg::GAIN_W-1:0]         gain;
    logic [CNT_W-1:0]                   cols;
    logic [hes_pkg::ROW_W-1:0]          rows;
    logic                               pipe_ready;
    logic                               accept;
    logic signed [hes_pkg::VALUE_W-1:0] s1_x, s1_centre, s1_right, s1_up, s1_left;
    hes_pkg::t_cell_tag                 s1_tag;

    // Input beat handshake.
    assign i_ready = i_rst_n && pipe_ready;
    assign accept  = i_valid && i_ready;

    hes_cfg_regs #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .CNT_W       (CNT_W)
    ) u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_gain      (gain),
        .o_cols      (cols),
        .o_rows      (rows)
    );

    hes_line_store #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .CNT_W       (CNT_W)
    ) u_line_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cell_value (i_cell_value),
        .i_cols       (cols),
        .i_rows       (rows),
        .o_x          (s1_x),
        .o_centre     (s1_centre),
        .o_right      (s1_right),
        .o_up         (s1_up),
        .o_left       (s1_left),
        .o_tag        (s1_tag)
    );

    hes_update_pipe u_update_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_x           (s1_x),
        .i_centre      (s1_centre),
        .i_right       (s1_right),
        .i_up          (s1_up),
        .i_left        (s1_left),
        .i_tag         (s1_tag),
        .i_gain        (gain),
        .i_out_ready   (o_ready),
        .o_in_ready    (pipe_ready),
        .o_valid       (o_valid),
        .o_new_value   (o_new_value),
        .o_out_row     (o_out_row),
        .o_out_column  (o_out_column),
        .o_last_of_run (o_last_of_run)
    );

endmodule

[hw/rtl/hes_cfg_regs.sv]
// Configuration registers of the heat stencil core and the clamped grid size.
// Depends on hes_pkg.
`timescale 1ns / 1ps

module hes_cfg_regs #(
    parameter int MAX_COLUMNS = hes_pkg::MAX_COLUMNS_DEF,
    parameter int CNT_W       = hes_pkg::COLS_CFG_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hes_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hes_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [hes_pkg::GAIN_W-1:0]          o_gain,
    output logic [CNT_W-1:0]                    o_cols,
    output logic [hes_pkg::ROW_W-1:0]           o_rows
);

    logic [hes_pkg::GAIN_W-1:0]     r_gain;
    logic [hes_pkg::COLS_CFG_W-1:0] r_cols;
    logic [hes_pkg::ROW_W-1:0]      r_rows;
    logic [CNT_W-1:0]               cols_ext;

    // Register writes; an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= hes_pkg::GAIN_RST;
            r_cols <= hes_pkg::COLS_RST;
            r_rows <= hes_pkg::ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hes_pkg::CFG_DIFFUSION_GAIN: r_gain <= i_cfg_data[hes_pkg::GAIN_W-1:0];
                hes_pkg::CFG_GRID_COLUMNS:   r_cols <= i_cfg_data[hes_pkg::COLS_CFG_W-1:0];
                hes_pkg::CFG_GRID_ROWS:      r_rows <= i_cfg_data[hes_pkg::ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the grid size to what the line stores and the stencil support.
    always_comb begin
        cols_ext = CNT_W'(r_cols);
        if (cols_ext < CNT_W'(hes_pkg::MIN_DIM)) begin
            o_cols = CNT_W'(hes_pkg::MIN_DIM);
        end else if (cols_ext > CNT_W'(MAX_COLUMNS)) begin
            o_cols = CNT_W'(MAX_COLUMNS);
        end else begin
            o_cols = cols_ext;
        end
        if (r_rows < hes_pkg::ROW_W'(hes_pkg::MIN_DIM)) begin
            o_rows = hes_pkg::ROW_W'(hes_pkg::MIN_DIM);
        end else begin
            o_rows = r_rows;
        end
    end

    assign o_gain = r_gain;

endmodule

[hw/rtl/hes_line_store.sv]
// Raster position tracking, the two line stores and the input stage registers.
// Depends on hes_pkg.
`timescale 1ns / 1ps

module hes_line_store #(
    parameter int MAX_COLUMNS = hes_pkg::MAX_COLUMNS_DEF,
    parameter int CNT_W       = hes_pkg::COLS_CFG_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic signed [hes_pkg::VALUE_W-1:0]  i_cell_value,
    input  logic [CNT_W-1:0]                    i_cols,
    input  logic [hes_pkg::ROW_W-1:0]           i_rows,
    output logic signed [hes_pkg::VALUE_W-1:0]  o_x,
    output logic signed [hes_pkg::VALUE_W-1:0]  o_centre,
    output logic signed [hes_pkg::VALUE_W-1:0]  o_right,
    output logic signed [hes_pkg::VALUE_W-1:0]  o_up,
    output logic signed [hes_pkg::VALUE_W-1:0]  o_left,
    output hes_pkg::t_cell_tag                  o_tag
);

    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // Line stores: the row just above the current one and the row above that.
    logic signed [hes_pkg::VALUE_W-1:0] r_prev_mem  [MAX_COLUMNS];
    logic signed [hes_pkg::VALUE_W-1:0] r_older_mem [MAX_COLUMNS];

    logic [hes_pkg::ROW_W-1:0]  r_row, n_row;
    logic [CW-1:0]              r_col, n_col;
    logic                       r_older_we;
    logic [CW-1:0]              r_older_addr;

    logic [CNT_W:0]             col_ext;
    logic [CNT_W:0]             col_inc;
    logic [CNT_W:0]             cols_ext;
    logic [hes_pkg::ROW_W:0]    row_inc;
    logic [hes_pkg::ROW_W:0]    rows_ext;
    logic [CW-1:0]              right_addr;
    logic [CW+hes_pkg::OUT_COL_W-1:0] col_wide;
    hes_pkg::t_cell_tag         tag;

    // Classify the arriving cell and work out the next raster position.
    always_comb begin
        col_ext    = (CNT_W+1)'(r_col);
        col_inc    = col_ext + (CNT_W+1)'(1);
        cols_ext   = (CNT_W+1)'(i_cols);
        row_inc    = (hes_pkg::ROW_W+1)'(r_row) + (hes_pkg::ROW_W+1)'(1);
        rows_ext   = (hes_pkg::ROW_W+1)'(i_rows);
        right_addr = col_inc[CW-1:0];
        col_wide   = {{hes_pkg::OUT_COL_W{1'b0}}, r_col};

        tag.row      = r_row;
        tag.col      = col_wide[hes_pkg::OUT_COL_W-1:0];
        tag.interior = (r_row >= hes_pkg::ROW_W'(2)) && (r_row < i_rows)
                    && (r_col != '0) && (col_inc < cols_ext);
        tag.boundary = (r_row == '0) || (row_inc >= rows_ext)
                    || (r_col == '0) || (col_inc >= cols_ext);

        if (col_inc >= cols_ext) begin
            n_col = '0;
            n_row = (row_inc >= rows_ext) ? '0 : row_inc[hes_pkg::ROW_W-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = r_row;
        end
    end

    // Position counters and the deferred write of the older line store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_older_we <= 1'b0;
        end else begin
            r_older_we <= i_accept;
            if (i_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

    // Reads of both stores and the input stage registers, taken with each beat.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_prev_mem[r_col] <= i_cell_value;
            o_centre          <= r_prev_mem[r_col];
            o_right           <= r_prev_mem[right_addr];
            o_up              <= r_older_mem[r_col];
            o_left            <= o_centre;
            o_x               <= i_cell_value;
            o_tag             <= tag;
            r_older_addr      <= r_col;
        end
    end

    // The old value of the upper row moves into the older store in the cycle after the beat.
    always_ff @(posedge i_clk) begin
        if (r_older_we) begin
            r_older_mem[r_older_addr] <= o_centre;
        end
    end

endmodule

[hw/rtl/hes_update_pipe.sv]
// Stencil arithmetic pipeline (sum, multiply, round and saturate) and result stage.
// Depends on hes_pkg.
`timescale 1ns / 1ps

module hes_update_pipe (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic signed [hes_pkg::VALUE_W-1:0]  i_x,
    input  logic signed [hes_pkg::VALUE_W-1:0]  i_centre,
    input  logic signed [hes_pkg::VALUE_W-1:0]  i_right,
    input  logic signed [hes_pkg::VALUE_W-1:0]  i_up,
    input  logic signed [hes_pkg::VALUE_W-1:0]  i_left,
    input  hes_pkg::t_cell_tag                  i_tag,
    input  logic [hes_pkg::GAIN_W-1:0]          i_gain,
    input  logic                                i_out_ready,
    output logic                                o_in_ready,
    output logic                                o_valid,
    output logic signed [hes_pkg::VALUE_W-1:0]  o_new_value,
    output logic [hes_pkg::ROW_W-1:0]           o_out_row,
    output logic [hes_pkg::OUT_COL_W-1:0]       o_out_column,
    output logic                                o_last_of_run
);

    localparam logic signed [hes_pkg::TOT_W-1:0] SAT_HI =
        hes_pkg::TOT_W'({1'b0, {(hes_pkg::VALUE_W-1){1'b1}}});
    localparam logic signed [hes_pkg::TOT_W-1:0] SAT_LO = -SAT_HI - 1;

    logic r_v1, r_v2, r_v3;
    logic r_p_int, r_p_bnd;
    logic mv1, mv2, mv3, s4_free;

    logic signed [hes_pkg::SUM_W-1:0]   r2_sum;
    logic signed [hes_pkg::VALUE_W-1:0] r2_centre, r2_x;
    hes_pkg::t_cell_tag                 r2_tag;

    logic signed [hes_pkg::PROD_W-1:0]  r3_prod;
    logic signed [hes_pkg::VALUE_W-1:0] r3_centre, r3_x;
    hes_pkg::t_cell_tag                 r3_tag;

    logic signed [hes_pkg::VALUE_W-1:0] r4_int_val, r4_bnd_val;
    hes_pkg::t_cell_tag                 r4_tag;

    logic signed [hes_pkg::SUM_W-1:0]   n_sum;
    logic signed [hes_pkg::PROD_W-1:0]  n_prod;
    logic signed [hes_pkg::TOT_W-1:0]   upd;
    logic signed [hes_pkg::TOT_W-1:0]   total;
    logic signed [hes_pkg::VALUE_W-1:0] n_int_val;

    // Stage handshake: each stage moves on when the stage below is empty or moving.
    always_comb begin
        s4_free    = (!r_p_int && !r_p_bnd) || (i_out_ready && !(r_p_int && r_p_bnd));
        mv3        = r_v3 && s4_free;
        mv2        = r_v2 && (!r_v3 || mv3);
        mv1        = r_v1 && (!r_v2 || mv2);
        o_in_ready = !r_v1 || mv1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_p_int <= 1'b0;
            r_p_bnd <= 1'b0;
        end else begin
            if (i_accept) begin
                r_v1 <= 1'b1;
            end else if (mv1) begin
                r_v1 <= 1'b0;
            end
            if (mv1) begin
                r_v2 <= 1'b1;
            end else if (mv2) begin
                r_v2 <= 1'b0;
            end
            if (mv2) begin
                r_v3 <= 1'b1;
            end else if (mv3) begin
                r_v3 <= 1'b0;
            end
            // The interior update leaves first, then the boundary cell.
            if (mv3) begin
                r_p_int <= r3_tag.interior;
                r_p_bnd <= r3_tag.boundary;
            end else if (o_valid && i_out_ready) begin
                if (r_p_int) begin
                    r_p_int <= 1'b0;
                end else begin
                    r_p_bnd <= 1'b0;
                end
            end
        end
    end

    // Neighbor sum minus four times the centre; exact in SUM_W bits.
    assign n_sum = hes_pkg::SUM_W'(i_up) + hes_pkg::SUM_W'(i_x)
                 + hes_pkg::SUM_W'(i_left) + hes_pkg::SUM_W'(i_right)
                 - (hes_pkg::SUM_W'(i_centre) <<< 2);

    // Product with the unsigned Q0.16 gain.
    assign n_prod = hes_pkg::PROD_W'(r2_sum)
                  * hes_pkg::PROD_W'($signed({1'b0, i_gain}));

    // Drop the fraction (floor), add the centre and clamp to the value range.
    always_comb begin
        upd   = hes_pkg::TOT_W'($signed(r3_prod[hes_pkg::PROD_W-1:hes_pkg::FRAC_W]));
        total = hes_pkg::TOT_W'(r3_centre) + upd;
        if (total > SAT_HI) begin
            n_int_val = SAT_HI[hes_pkg::VALUE_W-1:0];
        end else if (total < SAT_LO) begin
            n_int_val = SAT_LO[hes_pkg::VALUE_W-1:0];
        end else begin
            n_int_val = total[hes_pkg::VALUE_W-1:0];
        end
    end

    // Payload registers of stages two to four.
    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r2_sum    <= n_sum;
            r2_centre <= i_centre;
            r2_x      <= i_x;
            r2_tag    <= i_tag;
        end
        if (mv2) begin
            r3_prod   <= n_prod;
            r3_centre <= r2_centre;
            r3_x      <= r2_x;
            r3_tag    <= r2_tag;
        end
        if (mv3) begin
            r4_int_val <= n_int_val;
            r4_bnd_val <= r3_x;
            r4_tag     <= r3_tag;
        end
    end

    // Result beat: the interior cell sits one row above the arriving cell.
    always_comb begin
        o_valid       = r_p_int || r_p_bnd;
        o_new_value   = r_p_int ? r4_int_val : r4_bnd_val;
        o_out_row     = r_p_int ? (r4_tag.row - hes_pkg::ROW_W'(1)) : r4_tag.row;
        o_out_column  = r4_tag.col;
        o_last_of_run = !(r_p_int && r_p_bnd);
    end

endmodule

[hw/rtl/hes_checker.sv]
// Port-level checks of the heat stencil core, bound to the top level.
// Depends on hes_pkg and heat_explicit_stencil_step_core.
`timescale 1ns / 1ps

module hes_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_valid,
    input  logic                                o_ready,
    input  logic signed [hes_pkg::VALUE_W-1:0]  o_new_value,
    input  logic [hes_pkg::ROW_W-1:0]           o_out_row,
    input  logic [hes_pkg::OUT_COL_W-1:0]       o_out_column,
    input  logic                                o_last_of_run
);

    // Nothing is offered on the result side right after a reset cycle.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result beat holds its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_new_value)
            && $stable(o_out_row) && $stable(o_out_column))
        else $error("stalled result changed");

    // The first of a pair is an interior cell, never in the first column.
    a_pair_not_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> o_out_column != '0 && o_out_row != '0)
        else $error("interior update on an edge");

    // The second of a pair follows at once, same column, one row further down.
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ready && !o_last_of_run |=> o_valid && o_last_of_run
            && o_out_column == $past(o_out_column)
            && o_out_row == $past(o_out_row) + hes_pkg::ROW_W'(1))
        else $error("boundary beat of a pair missing or misplaced");

endmodule

bind heat_explicit_stencil_step_core hes_checker u_hes_checker (.*);
